// ===== rtl/osfc_pkg.sv =====
// Shared types, constants and helper functions for the observer feedback controller.
package osfc_pkg;

   localparam int CFG_W                  = 24;
   localparam int IN_W                   = 16;
   localparam int OUT_W                  = 16;
   localparam int REG_COUNT              = 8;
   localparam int REG_IDX_W              = 3;
   localparam int ADDR_W                 = 5;
   localparam int DATA_W                 = 32;
   localparam int COEF_FRAC_BITS_DEFAULT = 20;
   localparam int STATE_WIDTH_DEFAULT    = 24;

   // Sequencer length: eleven products plus pipeline drain.
   localparam int STEP_COUNT = 13;
   localparam int STEP_W     = 4;

   typedef enum logic [REG_IDX_W-1:0] {
      REG_SYS_PP = 3'd0,
      REG_SYS_PV = 3'd1,
      REG_SYS_VP = 3'd2,
      REG_SYS_VV = 3'd3,
      REG_OBS_P  = 3'd4,
      REG_OBS_V  = 3'd5,
      REG_FB_P   = 3'd6,
      REG_FB_V   = 3'd7
   } reg_index_type;

   typedef logic [REG_COUNT-1:0][CFG_W-1:0] coef_bank_type;

   localparam coef_bank_type COEF_RESET = {
      24'(-405904),  // REG_FB_V
      24'(-730753),  // REG_FB_P
      24'(1457311),  // REG_OBS_V
      24'(215063),   // REG_OBS_P
      24'(1006843),  // REG_SYS_VV
      24'(-1511313), // REG_SYS_VP
      24'(6606),     // REG_SYS_PV
      24'(833303)    // REG_SYS_PP
   };

   typedef enum logic {
      MODE_STEP = 1'b0,
      MODE_INIT = 1'b1
   } mode_type;

   typedef enum logic [3:0] {
      MUL_NONE,
      MUL_M00,
      MUL_M01,
      MUL_L0,
      MUL_M3P,
      MUL_M10,
      MUL_M11,
      MUL_L1,
      MUL_M3V,
      MUL_NBAR,
      MUL_K0,
      MUL_K1
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD,
      ACC_SUB
   } acc_mode_type;

   typedef enum logic [1:0] {
      FIN_NONE,
      FIN_POS,
      FIN_VEL,
      FIN_DRIVE
   } fin_sel_type;

   typedef struct packed {
      mul_sel_type  mul_sel;
      acc_mode_type acc_mode;
      fin_sel_type  fin_sel;
   } dp_step_type;

   typedef struct packed {
      logic        capture;
      logic        init_load;
      dp_step_type step;
   } dp_cmd_type;

   typedef enum logic {
      ST_IDLE,
      ST_RUN
   } ctrl_state_type;

   // Round num_e4 / 10000 * 2^frac_bits to nearest, halves away from zero.
   function automatic longint coef_const(input longint num_e4, input int frac_bits);
      longint one;
      one = longint'(1) <<< frac_bits;
      if (num_e4 >= 0) begin
         return (num_e4 * one + 5000) / 10000;
      end else begin
         return -(((-num_e4) * one + 5000) / 10000);
      end
   endfunction

endpackage

// ===== rtl/observer_state_feedback_controller_unit.sv =====
// Top level of the observer plus state-feedback controller.
// Each control-step transaction (mode 0) carries a measured and a target position in
// signed Q8.8. The block updates its position and velocity estimates as
// x' = M1*x + L*y + M3*r and returns drive = -K*x' + Nbar*r, with every sum of products
// formed exactly, floored by the coefficient fraction width and saturated; the saturated
// flag reports any clip in the two new estimates or in the drive. An initialize
// transaction (mode 1) loads the position estimate with the measurement, clears the
// velocity estimate and returns nothing. Schedule: one shared multiplier produces the
// eleven products one per cycle, feeding an accumulator through a product register; a
// control step writes its result once the output register is free, and the next
// transaction is taken after that write. req_stall is high while a step is in work.
// The result sits in an output register, so a step is accepted while the previous result
// still waits. Gains M1, L and K are written through the APB-style port at byte address
// 4*i (i in register order) and should only be changed while the block is idle; M3 and
// Nbar are built in.
module observer_state_feedback_controller_unit #(
   parameter int COEF_FRAC_BITS = osfc_pkg::COEF_FRAC_BITS_DEFAULT,
   parameter int STATE_WIDTH    = osfc_pkg::STATE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_valid,
   output logic                              req_stall,
   input  logic                              req_mode,
   input  logic signed [osfc_pkg::IN_W-1:0]  req_measured_pos,
   input  logic signed [osfc_pkg::IN_W-1:0]  req_target_pos,
   // response channel
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic signed [osfc_pkg::OUT_W-1:0] rsp_drive_angle,
   output logic                              rsp_saturated,
   // configuration port
   input  logic                              psel,
   input  logic                              penable,
   input  logic                              pwrite,
   input  logic [osfc_pkg::ADDR_W-1:0]       paddr,
   input  logic [osfc_pkg::DATA_W-1:0]       pwdata,
   output logic [osfc_pkg::DATA_W-1:0]       prdata,
   output logic                              pready
);
   import osfc_pkg::*;

   coef_bank_type coef;  // current gain set
   dp_cmd_type    cmd;   // per-cycle datapath command from the sequencer

   // Gain registers; writes land directly, reads come back sign-extended.
   osfc_csr u_csr (
      .clock   (clock),
      .reset   (reset),
      .psel    (psel),
      .penable (penable),
      .pwrite  (pwrite),
      .paddr   (paddr),
      .pwdata  (pwdata),
      .prdata  (prdata),
      .pready  (pready),
      .coef    (coef)
   );

   // Sequencer: accepts a transaction, walks the product schedule, owns response valid.
   osfc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_mode  (req_mode),
      .req_stall (req_stall),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .cmd       (cmd)
   );

   // Datapath: operand select, multiplier, accumulator, clip, estimates, output register.
   osfc_dp #(
      .COEF_FRAC_BITS (COEF_FRAC_BITS),
      .STATE_WIDTH    (STATE_WIDTH)
   ) u_dp (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .coef             (coef),
      .req_measured_pos (req_measured_pos),
      .req_target_pos   (req_target_pos),
      .rsp_drive_angle  (rsp_drive_angle),
      .rsp_saturated    (rsp_saturated)
   );

endmodule

// ===== rtl/osfc_csr.sv =====
// Register bank for the controller gains with an APB-style access port.
module osfc_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         psel,
   input  logic                         penable,
   input  logic                         pwrite,
   input  logic [osfc_pkg::ADDR_W-1:0]  paddr,
   input  logic [osfc_pkg::DATA_W-1:0]  pwdata,
   output logic [osfc_pkg::DATA_W-1:0]  prdata,
   output logic                         pready,
   output osfc_pkg::coef_bank_type      coef
);
   import osfc_pkg::*;

   coef_bank_type         regs_ff;
   coef_bank_type         regs_in;
   logic [REG_IDX_W-1:0]  idx;

   assign idx    = paddr[ADDR_W-1:2];
   assign pready = 1'b1;
   assign coef   = regs_ff;
   assign prdata = DATA_W'(signed'(regs_ff[idx]));

   always_comb begin
      regs_in = regs_ff;
      if (psel && penable && pwrite) begin
         regs_in[idx] = pwdata[CFG_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         regs_ff <= COEF_RESET;
      end else begin
         regs_ff <= regs_in;
      end
   end

endmodule

// ===== rtl/osfc_ctrl.sv =====
// Sequencer that steps the shared multiply-accumulate datapath through one control step.
module osfc_ctrl (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   input  logic                 req_mode,
   output logic                 req_stall,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output osfc_pkg::dp_cmd_type cmd
);
   import osfc_pkg::*;

   // Per-step schedule: product issue, accumulate from the product register, finish from the accumulator.
   localparam dp_step_type STEP_TABLE [STEP_COUNT] = '{
      '{MUL_M00,  ACC_HOLD, FIN_NONE},
      '{MUL_M01,  ACC_LOAD, FIN_NONE},
      '{MUL_L0,   ACC_ADD,  FIN_NONE},
      '{MUL_M3P,  ACC_ADD,  FIN_NONE},
      '{MUL_M10,  ACC_ADD,  FIN_NONE},
      '{MUL_M11,  ACC_LOAD, FIN_POS},
      '{MUL_L1,   ACC_ADD,  FIN_NONE},
      '{MUL_M3V,  ACC_ADD,  FIN_NONE},
      '{MUL_NBAR, ACC_ADD,  FIN_NONE},
      '{MUL_K0,   ACC_LOAD, FIN_VEL},
      '{MUL_K1,   ACC_SUB,  FIN_NONE},
      '{MUL_NONE, ACC_SUB,  FIN_NONE},
      '{MUL_NONE, ACC_HOLD, FIN_DRIVE}
   };
   localparam logic [STEP_W-1:0] STEP_LAST = STEP_W'(STEP_COUNT - 1);
   localparam dp_step_type STEP_IDLE = '{MUL_NONE, ACC_HOLD, FIN_NONE};

   ctrl_state_type      state_ff, state_in;
   logic [STEP_W-1:0]   cnt_ff, cnt_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic                out_busy;
   logic                accept;

   assign out_busy  = rsp_valid_ff && rsp_stall;
   assign rsp_valid = rsp_valid_ff;

   // Next state
   always_comb begin
      state_in     = state_ff;
      cnt_in       = cnt_ff;
      rsp_valid_in = out_busy;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid && (req_mode == MODE_STEP)) begin
               state_in = ST_RUN;
               cnt_in   = '0;
            end
         end
         ST_RUN: begin
            if (cnt_ff == STEP_LAST) begin
               if (!out_busy) begin
                  state_in     = ST_IDLE;
                  rsp_valid_in = 1'b1;
               end
            end else begin
               cnt_in = cnt_ff + 1'b1;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Outputs
   always_comb begin
      req_stall     = 1'b1;
      cmd.capture   = 1'b0;
      cmd.init_load = 1'b0;
      cmd.step      = STEP_IDLE;
      accept        = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_stall     = 1'b0;
            accept        = req_valid;
            cmd.capture   = accept;
            cmd.init_load = accept && (req_mode == MODE_INIT);
         end
         ST_RUN: begin
            cmd.step = STEP_TABLE[cnt_ff];
            // hold the final write until the output register frees up
            if ((cnt_ff == STEP_LAST) && out_busy) begin
               cmd.step = STEP_IDLE;
            end
         end
         default: begin
            req_stall = 1'b1;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

// ===== rtl/osfc_dp.sv =====
// Datapath: shared multiplier, accumulator, saturation and estimate registers.
module osfc_dp #(
   parameter int COEF_FRAC_BITS = osfc_pkg::COEF_FRAC_BITS_DEFAULT,
   parameter int STATE_WIDTH    = osfc_pkg::STATE_WIDTH_DEFAULT
) (
   input  logic                              clock,
   input  logic                              reset,
   input  osfc_pkg::dp_cmd_type              cmd,
   input  osfc_pkg::coef_bank_type           coef,
   input  logic signed [osfc_pkg::IN_W-1:0]  req_measured_pos,
   input  logic signed [osfc_pkg::IN_W-1:0]  req_target_pos,
   output logic signed [osfc_pkg::OUT_W-1:0] rsp_drive_angle,
   output logic                              rsp_saturated
);
   import osfc_pkg::*;

   localparam int CW     = (COEF_FRAC_BITS + 1 > CFG_W) ? COEF_FRAC_BITS + 1 : CFG_W;
   localparam int PROD_W = CW + STATE_WIDTH;
   localparam int ACC_W  = PROD_W + 2;

   localparam logic signed [CW-1:0] M3P_C  = CW'(coef_const(2, COEF_FRAC_BITS));
   localparam logic signed [CW-1:0] M3V_C  = CW'(coef_const(521, COEF_FRAC_BITS));
   localparam logic signed [CW-1:0] NBAR_C = CW'(coef_const(-6969, COEF_FRAC_BITS));

   logic signed [STATE_WIDTH-1:0] est_pos_ff, est_pos_in;
   logic signed [STATE_WIDTH-1:0] est_vel_ff, est_vel_in;
   logic signed [IN_W-1:0]        y_ff, r_ff;
   logic signed [PROD_W-1:0]      prod_ff, prod_in;
   logic signed [ACC_W-1:0]       acc_ff, acc_in;
   logic signed [OUT_W-1:0]       drive_ff, drive_in;
   logic                          sat_ff, sat_in;
   logic                          hit_ff, hit_in;

   logic signed [CW-1:0]          a_op;
   logic signed [STATE_WIDTH-1:0] b_op;
   logic signed [ACC_W-1:0]       sh;
   logic                          st_ovf, out_ovf;
   logic signed [STATE_WIDTH-1:0] st_sat;
   logic signed [OUT_W-1:0]       out_sat;

   assign rsp_drive_angle = drive_ff;
   assign rsp_saturated   = sat_ff;

   // Operand select for the shared multiplier
   always_comb begin
      a_op = '0;
      b_op = '0;
      case (cmd.step.mul_sel)
         MUL_M00:  begin a_op = CW'(signed'(coef[REG_SYS_PP])); b_op = est_pos_ff; end
         MUL_M01:  begin a_op = CW'(signed'(coef[REG_SYS_PV])); b_op = est_vel_ff; end
         MUL_L0:   begin a_op = CW'(signed'(coef[REG_OBS_P]));  b_op = STATE_WIDTH'(y_ff); end
         MUL_M3P:  begin a_op = M3P_C;                          b_op = STATE_WIDTH'(r_ff); end
         MUL_M10:  begin a_op = CW'(signed'(coef[REG_SYS_VP])); b_op = est_pos_ff; end
         MUL_M11:  begin a_op = CW'(signed'(coef[REG_SYS_VV])); b_op = est_vel_ff; end
         MUL_L1:   begin a_op = CW'(signed'(coef[REG_OBS_V]));  b_op = STATE_WIDTH'(y_ff); end
         MUL_M3V:  begin a_op = M3V_C;                          b_op = STATE_WIDTH'(r_ff); end
         MUL_NBAR: begin a_op = NBAR_C;                         b_op = STATE_WIDTH'(r_ff); end
         MUL_K0:   begin a_op = CW'(signed'(coef[REG_FB_P]));   b_op = est_pos_ff; end
         MUL_K1:   begin a_op = CW'(signed'(coef[REG_FB_V]));   b_op = est_vel_ff; end
         default:  begin a_op = '0;                             b_op = '0; end
      endcase
   end

   assign prod_in = PROD_W'(a_op) * PROD_W'(b_op);

   always_comb begin
      case (cmd.step.acc_mode)
         ACC_LOAD: acc_in = ACC_W'(prod_ff);
         ACC_ADD:  acc_in = acc_ff + ACC_W'(prod_ff);
         ACC_SUB:  acc_in = acc_ff - ACC_W'(prod_ff);
         default:  acc_in = acc_ff;
      endcase
   end

   // Floor shift and clip to the state and drive widths
   assign sh      = acc_ff >>> COEF_FRAC_BITS;
   assign st_ovf  = !((&sh[ACC_W-1:STATE_WIDTH-1]) || !(|sh[ACC_W-1:STATE_WIDTH-1]));
   assign st_sat  = st_ovf ? {sh[ACC_W-1], {(STATE_WIDTH-1){~sh[ACC_W-1]}}}
                           : sh[STATE_WIDTH-1:0];
   assign out_ovf = !((&sh[ACC_W-1:OUT_W-1]) || !(|sh[ACC_W-1:OUT_W-1]));
   assign out_sat = out_ovf ? {sh[ACC_W-1], {(OUT_W-1){~sh[ACC_W-1]}}}
                            : sh[OUT_W-1:0];

   always_comb begin
      est_pos_in = est_pos_ff;
      est_vel_in = est_vel_ff;
      drive_in   = drive_ff;
      sat_in     = sat_ff;
      hit_in     = hit_ff;
      if (cmd.capture) begin
         hit_in = 1'b0;
      end
      if (cmd.init_load) begin
         est_pos_in = STATE_WIDTH'(req_measured_pos);
         est_vel_in = '0;
      end
      case (cmd.step.fin_sel)
         FIN_POS: begin
            est_pos_in = st_sat;
            hit_in     = hit_ff | st_ovf;
         end
         FIN_VEL: begin
            est_vel_in = st_sat;
            hit_in     = hit_ff | st_ovf;
         end
         FIN_DRIVE: begin
            drive_in = out_sat;
            sat_in   = hit_ff | out_ovf;
         end
         default: begin
            drive_in = drive_ff;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         est_pos_ff <= '0;
         est_vel_ff <= '0;
      end else begin
         est_pos_ff <= est_pos_in;
         est_vel_ff <= est_vel_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         y_ff <= req_measured_pos;
         r_ff <= req_target_pos;
      end
      prod_ff  <= prod_in;
      acc_ff   <= acc_in;
      drive_ff <= drive_in;
      sat_ff   <= sat_in;
      hit_ff   <= hit_in;
   end

endmodule

// ===== tb/tb_observer_state_feedback_controller_unit.sv =====
// Self-checking testbench for the observer plus state-feedback controller unit.
`timescale 1ns / 1ps

module tb_observer_state_feedback_controller_unit;
   import osfc_pkg::*;

   // Fixed-point setup of the instance under test.
   localparam int COEF_FRAC = COEF_FRAC_BITS_DEFAULT;
   localparam int STATE_W   = STATE_WIDTH_DEFAULT;

   // Built-in input and reference gains, Q3.20: M3 = {0.0002, 0.0521}, Nbar = -0.6969.
   localparam longint TARGET_TO_POS = 210;
   localparam longint TARGET_TO_VEL = 54631;
   localparam longint TARGET_TO_DRV = -730753;

   // Cycles to let pass once nothing is outstanding: covers a step still in work.
   localparam int SETTLE_CYCLES = 20;
   // Length of the long receiver hold-off that backs up the request side.
   localparam int HOLD_CYCLES   = 200;

   typedef enum int {
      GAINS_RESET,
      GAINS_MAX,
      GAINS_MIN,
      GAINS_ZERO,
      GAINS_WIDE,
      GAINS_SMALL
   } gain_set_type;

   typedef struct {
      logic signed [OUT_W-1:0] angle;
      logic                    clipped;
   } drive_result_type;

   // Tracks the estimator state and gains, predicts each drive and checks
   // results in order against what is still outstanding.
   class drive_scoreboard;
      longint           gain [REG_COUNT];
      longint           est_pos;
      longint           est_vel;
      drive_result_type pending_drives [$];
      int               errors;
      int               steps;
      int               inits;
      int               checked;
      int               clipped;

      function new();
         for (int i = 0; i < REG_COUNT; i++) begin
            gain[i] = $signed(COEF_RESET[i]);
         end
         est_pos = 0;
         est_vel = 0;
      endfunction

      function void set_gain(int idx, logic [CFG_W-1:0] value);
         gain[idx] = $signed(value);
      endfunction

      function longint clamp_to(longint x, int w, inout bit hit);
         longint hi;
         longint lo;
         hi = (longint'(1) <<< (w - 1)) - 1;
         lo = -hi - 1;
         if (x > hi) begin
            hit = 1'b1;
            return hi;
         end
         if (x < lo) begin
            hit = 1'b1;
            return lo;
         end
         return x;
      endfunction

      // Advance the estimate for one accepted transaction and queue its drive.
      function void note_request(mode_type m, logic signed [IN_W-1:0] y_in,
                                 logic signed [IN_W-1:0] r_in);
         longint           y;
         longint           r;
         longint           acc;
         longint           np;
         longint           nv;
         longint           u;
         bit               hit;
         drive_result_type res;
         y   = y_in;
         r   = r_in;
         hit = 1'b0;
         if (m == MODE_INIT) begin
            est_pos = y;
            est_vel = 0;
            inits++;
            return;
         end
         acc = gain[REG_SYS_PP] * est_pos + gain[REG_SYS_PV] * est_vel
             + gain[REG_OBS_P] * y + TARGET_TO_POS * r;
         np  = clamp_to(acc >>> COEF_FRAC, STATE_W, hit);
         acc = gain[REG_SYS_VP] * est_pos + gain[REG_SYS_VV] * est_vel
             + gain[REG_OBS_V] * y + TARGET_TO_VEL * r;
         nv  = clamp_to(acc >>> COEF_FRAC, STATE_W, hit);
         est_pos = np;
         est_vel = nv;
         acc = (-gain[REG_FB_P]) * np + (-gain[REG_FB_V]) * nv + TARGET_TO_DRV * r;
         u   = clamp_to(acc >>> COEF_FRAC, OUT_W, hit);
         res.angle   = OUT_W'(u);
         res.clipped = hit;
         pending_drives.push_back(res);
         steps++;
         if (hit) clipped++;
      endfunction

      task report_mismatch(string msg);
         if (errors < 40) $display("MISMATCH: %s", msg);
         errors++;
      endtask

      task check_drive(logic signed [OUT_W-1:0] angle, logic sat);
         drive_result_type want;
         if (pending_drives.size() == 0) begin
            report_mismatch($sformatf("result with nothing outstanding: angle %0d sat %0b",
                                      angle, sat));
            return;
         end
         want = pending_drives.pop_front();
         checked++;
         if (angle !== want.angle || sat !== want.clipped) begin
            report_mismatch($sformatf("result %0d: angle %0d sat %0b, predicted %0d sat %0b",
                                      checked, angle, sat, want.angle, want.clipped));
         end
      endtask
   endclass

   logic                     clock            = 1'b0;
   logic                     reset            = 1'b1;
   logic                     req_valid        = 1'b0;
   logic                     req_stall;
   logic                     req_mode         = MODE_STEP;
   logic signed [IN_W-1:0]   req_measured_pos = '0;
   logic signed [IN_W-1:0]   req_target_pos   = '0;
   logic                     rsp_valid;
   logic                     rsp_stall        = 1'b0;
   logic signed [OUT_W-1:0]  rsp_drive_angle;
   logic                     rsp_saturated;
   logic                     psel             = 1'b0;
   logic                     penable          = 1'b0;
   logic                     pwrite           = 1'b0;
   logic [ADDR_W-1:0]        paddr            = '0;
   logic [DATA_W-1:0]        pwdata           = '0;
   logic [DATA_W-1:0]        prdata;
   logic                     pready;

   drive_scoreboard sb;

   // Idling controls shared by the request driver and the result sink.
   bit gaps_on      = 1'b0;
   bit stalls_on    = 1'b0;
   bit hold_request = 1'b0;
   int stall_left   = 0;
   int hold_left    = 0;

   observer_state_feedback_controller_unit #(
      .COEF_FRAC_BITS (COEF_FRAC),
      .STATE_WIDTH    (STATE_W)
   ) dut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_mode         (req_mode),
      .req_measured_pos (req_measured_pos),
      .req_target_pos   (req_target_pos),
      .rsp_valid        (rsp_valid),
      .rsp_stall        (rsp_stall),
      .rsp_drive_angle  (rsp_drive_angle),
      .rsp_saturated    (rsp_saturated),
      .psel             (psel),
      .penable          (penable),
      .pwrite           (pwrite),
      .paddr            (paddr),
      .pwdata           (pwdata),
      .prdata           (prdata),
      .pready           (pready)
   );

   // 2 ns clock.
   always begin
      #1 clock = 1'b1;
      #1 clock = 1'b0;
   end

   // Result sink: check every accepted result, then decide the stall for the
   // next edge. A long hold-off requested by the stimulus overrides the random
   // bursts and is counted down here.
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         stall_left = 0;
         hold_left  = 0;
      end else begin
         if (rsp_valid && !rsp_stall) sb.check_drive(rsp_drive_angle, rsp_saturated);
         if (hold_request) begin
            hold_request = 1'b0;
            hold_left    = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else if (stall_left > 0) begin
            stall_left--;
            rsp_stall <= 1'b1;
         end else if (stalls_on && $urandom_range(0, 5) == 0) begin
            stall_left = $urandom_range(0, 7);
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= 1'b0;
         end
      end
   end

   // Offer one transaction, optionally after a random gap, and hold it until
   // the block takes it. Valid stays high on return so back-to-back
   // transactions need no second assignment in one step.
   task automatic send_request(input mode_type m, input logic signed [IN_W-1:0] y,
                               input logic signed [IN_W-1:0] r);
      int gap;
      if (gaps_on && $urandom_range(0, 4) == 0) begin
         gap = $urandom_range(1, 8);
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_valid        <= 1'b1;
      req_mode         <= m;
      req_measured_pos <= y;
      req_target_pos   <= r;
      do @(posedge clock); while (req_stall);
      sb.note_request(m, y, r);
   endtask

   // Drop valid and wait for every outstanding drive, then let the block go quiet.
   task automatic settle_block();
      req_valid <= 1'b0;
      @(posedge clock);
      while (sb.pending_drives.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // One APB write: setup, then access; the register takes it at the access edge.
   task automatic write_gain(input reg_index_type idx, input logic [CFG_W-1:0] value);
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= ADDR_W'(int'(idx) * 4);
      pwdata  <= {{(DATA_W - CFG_W){value[CFG_W-1]}}, value};
      @(posedge clock);
      penable <= 1'b1;
      do @(posedge clock); while (!pready);
      sb.set_gain(idx, value);
   endtask

   // Write all eight gains from one named set; call only while idle.
   task automatic program_gains(input gain_set_type s);
      logic [CFG_W-1:0] v;
      for (int i = 0; i < REG_COUNT; i++) begin
         case (s)
            GAINS_RESET: v = COEF_RESET[i];
            GAINS_MAX:   v = {1'b0, {(CFG_W - 1){1'b1}}};
            GAINS_MIN:   v = {1'b1, {(CFG_W - 1){1'b0}}};
            GAINS_ZERO:  v = '0;
            GAINS_WIDE:  v = CFG_W'($urandom);
            default:     v = CFG_W'(int'($urandom_range(0, 1 << 20)) - (1 << 19));
         endcase
         write_gain(reg_index_type'(i), v);
      end
      psel    <= 1'b0;
      penable <= 1'b0;
      pwrite  <= 1'b0;
      @(posedge clock);
   endtask

   // Mostly positions within +-10 cm so the loop behaves like a real plant,
   // with a share of full-range values to hit the sign and top bits.
   function automatic logic signed [IN_W-1:0] random_position();
      if ($urandom_range(0, 3) == 0) return IN_W'($urandom);
      return IN_W'(int'($urandom_range(0, 5120)) - 2560);
   endfunction

   task automatic run_random(input int count);
      mode_type m;
      for (int k = 0; k < count; k++) begin
         m = ($urandom_range(0, 11) == 0) ? MODE_INIT : MODE_STEP;
         send_request(m, random_position(), random_position());
      end
   endtask

   initial begin
      sb = new();
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed: field extremes, initialize (with a target it must ignore),
      // saturation of drive and state, and floor on small negative values.
      send_request(MODE_INIT, 16'sd0, 16'sd0);
      send_request(MODE_STEP, 16'sd0, 16'sd0);
      send_request(MODE_STEP, 16'sh7fff, 16'sh7fff);
      send_request(MODE_STEP, 16'sh8000, 16'sh8000);
      send_request(MODE_STEP, 16'sh7fff, 16'sh8000);
      send_request(MODE_STEP, 16'sh7fff, 16'sh8000);
      send_request(MODE_STEP, 16'sh7fff, 16'sh8000);
      send_request(MODE_STEP, 16'sh8000, 16'sh7fff);
      send_request(MODE_STEP, 16'sh8000, 16'sh7fff);
      send_request(MODE_STEP, 16'sh8000, 16'sh7fff);
      send_request(MODE_INIT, 16'sh7fff, 16'sh8000);
      send_request(MODE_STEP, 16'sh7fff, 16'sd0);
      send_request(MODE_INIT, 16'sh8000, 16'sh7fff);
      send_request(MODE_STEP, 16'sh8000, 16'sd0);
      send_request(MODE_INIT, -16'sd1, 16'sd0);
      send_request(MODE_STEP, -16'sd1, 16'sd1);
      send_request(MODE_STEP, 16'sd1, -16'sd1);
      send_request(MODE_STEP, 16'sd256, 16'sd256);
      send_request(MODE_INIT, 16'sd100, 16'sh8000);
      send_request(MODE_STEP, 16'sd100, 16'sd0);
      settle_block();

      // Reset gains with idling on both sides; back up the block with a long
      // hold-off on results, and pause the sender midway until all drain.
      gaps_on   = 1'b1;
      stalls_on = 1'b1;
      run_random(100);
      hold_request = 1'b1;
      run_random(75);
      settle_block();
      run_random(175);
      settle_block();

      // Extreme gains drive the state and drive into saturation.
      program_gains(GAINS_MAX);
      run_random(100);
      settle_block();
      program_gains(GAINS_MIN);
      run_random(100);
      settle_block();
      program_gains(GAINS_ZERO);
      run_random(50);
      settle_block();

      // Arbitrary full-range gains, two draws.
      program_gains(GAINS_WIDE);
      run_random(150);
      settle_block();
      program_gains(GAINS_WIDE);
      run_random(150);
      settle_block();

      // Gains below one in magnitude keep the estimator mostly unclipped.
      program_gains(GAINS_SMALL);
      run_random(350);
      settle_block();

      // Back to reset gains; the tail runs at full rate with no idling.
      program_gains(GAINS_RESET);
      run_random(200);
      gaps_on   = 1'b0;
      stalls_on = 1'b0;
      run_random(300);
      settle_block();

      $display("Covered %0d control steps and %0d initializations over six gain sets.",
               sb.steps, sb.inits);
      $display("Checked %0d drive results, %0d of them clipped.", sb.checked, sb.clipped);
      if (sb.errors == 0) begin
         $display("Testbench completed without errors");
      end else begin
         $display("Testbench completed WITH ERRORS");
      end
      $finish;
   end

   // Hard stop well beyond the slowest legal run.
   initial begin
      #(2_000_000);
      $display("Timeout: %0d drive results still outstanding", sb.pending_drives.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
   end

endmodule
